// File: rtl/core/waiter_list_queue_macros.svh
// Assertion helpers for the waiter list queue.
// WLQ_ASSERT_IMPL checks cons in the same cycle as ante; WLQ_ASSERT_NEXT in the cycle after.
`ifndef WAITER_LIST_QUEUE_MACROS_SVH
`define WAITER_LIST_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define WLQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("waiter list queue: same-cycle check failed");
`define WLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("waiter list queue: next-cycle check failed");
`else
`define WLQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WLQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/wlq_pkg.sv
package wlq_pkg;

   localparam int SLOTS_DEFAULT    = 16;
   localparam int TID_BITS_DEFAULT = 16;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int TID_W      = 16;
   localparam int HANDLE_W   = 4;
   localparam int STATUS_W   = 2;
   localparam int TOTAL_W    = 5;

   // at most this many results per drain
   localparam int RESULT_LIMIT = 16;
   localparam int DRAIN_CNT_W  = $clog2(RESULT_LIMIT);

   // stream packing
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1 + STATUS_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - HANDLE_W - TID_W - TOTAL_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SHIFT  = 2'd2,
      OP_DRAIN  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TID_W-1:0]    thread_out;
      logic                thread_valid;
      status_type          status;
      logic [TOTAL_W-1:0]  waiter_total;
      logic                last;
   } rsp_type;

endpackage

// File: rtl/core/waiter_list_queue.sv
// Channel  | Dir | Handshake          | Payload
// req_*    | in  | tvalid / tready    | tdata: thread_id, waiter_handle; tuser: op
// rsp_*    | out | tvalid / tready    | tdata: handle, thread_out, waiter_total;
//          |     |                    | tuser: thread_valid, status; tlast: last
// Add, remove and shift run accept, execute, then link/unlink and result;
// a full table, unqueued handle or empty list is answered from execute.
// Drain reads one list entry and gives one result per cycle while results are taken.
// A stalled result port holds the sequencer in the step that produces the next result.
// Reset clears the occupancy bits, head, tail and count; no clearing pass is needed,
// since link and thread tables are only read for occupied slots.
`include "waiter_list_queue_macros.svh"

module waiter_list_queue #(
   parameter int SLOTS          = wlq_pkg::SLOTS_DEFAULT,
   parameter int THREAD_ID_BITS = wlq_pkg::TID_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [15:0] thread_id, [19:16] waiter_handle, rest zero
   input  logic [wlq_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [wlq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [3:0] handle, [19:4] thread_out, [24:20] waiter_total, rest zero
   output logic [wlq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] thread_valid, [2:1] status
   output logic [wlq_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int IW   = $clog2(SLOTS);
   localparam int PW   = $clog2(SLOTS + 1);
   localparam int CW   = PW;
   localparam int CMPW = PW + wlq_pkg::HANDLE_W;
   localparam int EW   = CW + wlq_pkg::TOTAL_W + 1;
   localparam logic [PW-1:0] NIL_PTR = PW'(SLOTS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_LINK   = 4'b0100,
      ST_UNLINK = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   wlq_pkg::op_type                   op_ff, op_in;
   logic [wlq_pkg::TID_W-1:0]         tid_ff, tid_in;
   logic [wlq_pkg::HANDLE_W-1:0]      hnd_ff, hnd_in;
   logic [IW-1:0]                     cur_ff, cur_in;
   logic [PW-1:0]                     link_ptr_ff, link_ptr_in;
   logic [PW-1:0]                     head_ff, head_in;
   logic [PW-1:0]                     tail_ff, tail_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [SLOTS-1:0]                  used_ff, used_in;
   logic [wlq_pkg::DRAIN_CNT_W-1:0]   drain_cnt_ff, drain_cnt_in;
   logic [CW-1:0]                     drain_total_ff, drain_total_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   wlq_pkg::rsp_type                  rsp_ff, rsp_in;

   // slot tables
   logic [THREAD_ID_BITS-1:0]         slot_thread_ff [SLOTS];
   logic [PW-1:0]                     slot_next_ff   [SLOTS];
   logic [PW-1:0]                     slot_prev_ff   [SLOTS];
   logic [THREAD_ID_BITS-1:0]         rd_thread_ff;
   logic [PW-1:0]                     rd_next_ff;
   logic [PW-1:0]                     rd_prev_ff;

   logic                              th_we, nx_we, pv_we;
   logic [IW-1:0]                     th_addr, nx_addr, pv_addr;
   logic [THREAD_ID_BITS-1:0]         th_wd;
   logic [PW-1:0]                     nx_wd, pv_wd;

   logic                              out_free;
   logic                              rsp_load;
   wlq_pkg::rsp_type                  res;
   logic [IW-1:0]                     free_idx;
   logic                              hnd_ok;
   logic [PW-1:0]                     unl_prev;
   logic                              unl_last;
   logic [EW-1:0]                     count_ext;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign hnd_ok = (CMPW'(hnd_ff) < CMPW'(SLOTS)) && used_ff[IW'(hnd_ff)];
   assign count_ext = EW'(count_ff);
   // only remove unlinks a non-head slot; the head's prev is null
   assign unl_prev = (op_ff == wlq_pkg::OP_REMOVE) ? rd_prev_ff : NIL_PTR;
   assign unl_last = (op_ff != wlq_pkg::OP_DRAIN) || (rd_next_ff == NIL_PTR) ||
                     (drain_cnt_ff == wlq_pkg::DRAIN_CNT_W'(wlq_pkg::RESULT_LIMIT - 1));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      tid_in         = tid_ff;
      hnd_in         = hnd_ff;
      cur_in         = cur_ff;
      link_ptr_in    = link_ptr_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      used_in        = used_ff;
      drain_cnt_in   = drain_cnt_ff;
      drain_total_in = drain_total_ff;
      th_we          = 1'b0;
      th_addr        = free_idx;
      th_wd          = THREAD_ID_BITS'({{THREAD_ID_BITS{1'b0}}, tid_ff});
      nx_we          = 1'b0;
      nx_addr        = free_idx;
      nx_wd          = NIL_PTR;
      pv_we          = 1'b0;
      pv_addr        = free_idx;
      pv_wd          = tail_ff;
      rsp_load       = 1'b0;
      res            = '0;
      res.status     = wlq_pkg::STATUS_OK;
      res.last       = 1'b1;
      res.waiter_total = wlq_pkg::TOTAL_W'({{wlq_pkg::TOTAL_W{1'b0}}, count_ff});

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = wlq_pkg::op_type'(req_tuser[wlq_pkg::OP_W-1:0]);
               tid_in   = req_tdata[wlq_pkg::TID_W-1:0];
               hnd_in   = req_tdata[wlq_pkg::TID_W +: wlq_pkg::HANDLE_W];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               wlq_pkg::OP_ADD: begin
                  if (count_ff == CW'(SLOTS)) begin
                     res.status = wlq_pkg::STATUS_FULL;
                     if (out_free) begin
                        rsp_load = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     th_we              = 1'b1;
                     nx_we              = 1'b1;
                     pv_we              = 1'b1;
                     used_in[free_idx]  = 1'b1;
                     count_in           = count_ff + CW'(1);
                     tail_in            = PW'(free_idx);
                     if (tail_ff == NIL_PTR) begin
                        head_in = PW'(free_idx);
                     end
                     link_ptr_in = tail_ff;
                     cur_in      = free_idx;
                     state_in    = ST_LINK;
                  end
               end
               wlq_pkg::OP_REMOVE: begin
                  if (!hnd_ok) begin
                     res.status = wlq_pkg::STATUS_MISS;
                     if (out_free) begin
                        rsp_load = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     cur_in   = IW'(hnd_ff);
                     state_in = ST_UNLINK;
                  end
               end
               default: begin
                  // shift and drain both pop from the head
                  if (head_ff == NIL_PTR) begin
                     res.status = wlq_pkg::STATUS_MISS;
                     if (out_free) begin
                        rsp_load = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     cur_in       = head_ff[IW-1:0];
                     drain_cnt_in = '0;
                     if (count_ext > EW'(wlq_pkg::RESULT_LIMIT)) begin
                        drain_total_in = CW'(count_ext - EW'(wlq_pkg::RESULT_LIMIT));
                     end else begin
                        drain_total_in = '0;
                     end
                     state_in = ST_UNLINK;
                  end
               end
            endcase
         end
         ST_LINK: begin
            res.handle = wlq_pkg::HANDLE_W'({{wlq_pkg::HANDLE_W{1'b0}}, cur_ff});
            if (out_free) begin
               if (link_ptr_ff != NIL_PTR) begin
                  nx_we   = 1'b1;
                  nx_addr = link_ptr_ff[IW-1:0];
                  nx_wd   = PW'(cur_ff);
               end
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_UNLINK: begin
            res.thread_valid = (op_ff != wlq_pkg::OP_REMOVE);
            if (op_ff != wlq_pkg::OP_REMOVE) begin
               res.thread_out = wlq_pkg::TID_W'({{wlq_pkg::TID_W{1'b0}}, rd_thread_ff});
            end
            if (op_ff == wlq_pkg::OP_DRAIN) begin
               res.waiter_total =
                  wlq_pkg::TOTAL_W'({{wlq_pkg::TOTAL_W{1'b0}}, drain_total_ff});
            end else begin
               res.waiter_total =
                  wlq_pkg::TOTAL_W'({{wlq_pkg::TOTAL_W{1'b0}}, count_ff - CW'(1)});
            end
            res.last = unl_last;
            if (out_free) begin
               if (unl_prev != NIL_PTR) begin
                  nx_we   = 1'b1;
                  nx_addr = unl_prev[IW-1:0];
                  nx_wd   = rd_next_ff;
               end else begin
                  head_in = rd_next_ff;
               end
               if (rd_next_ff != NIL_PTR) begin
                  pv_we   = 1'b1;
                  pv_addr = rd_next_ff[IW-1:0];
                  pv_wd   = unl_prev;
               end else begin
                  tail_in = unl_prev;
               end
               used_in[cur_ff] = 1'b0;
               count_in        = count_ff - CW'(1);
               rsp_load        = 1'b1;
               if (unl_last) begin
                  state_in = ST_IDLE;
               end else begin
                  // the next slot's link read lands for the following cycle
                  cur_in       = rd_next_ff[IW-1:0];
                  drain_cnt_in = drain_cnt_ff + wlq_pkg::DRAIN_CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL_PTR;
         tail_ff      <= NIL_PTR;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tid_ff         <= tid_in;
      hnd_ff         <= hnd_in;
      cur_ff         <= cur_in;
      link_ptr_ff    <= link_ptr_in;
      drain_cnt_ff   <= drain_cnt_in;
      drain_total_ff <= drain_total_in;
      rsp_ff         <= rsp_in;
   end

   // table reads follow the slot the sequencer moves to
   always_ff @(posedge clock) begin
      if (th_we) begin
         slot_thread_ff[th_addr] <= th_wd;
      end
      rd_thread_ff <= slot_thread_ff[cur_in];
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         slot_next_ff[nx_addr] <= nx_wd;
      end
      rd_next_ff <= slot_next_ff[cur_in];
   end

   always_ff @(posedge clock) begin
      if (pv_we) begin
         slot_prev_ff[pv_addr] <= pv_wd;
      end
      rd_prev_ff <= slot_prev_ff[cur_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{wlq_pkg::RSP_PAD_W{1'b0}}, rsp_ff.waiter_total,
                        rsp_ff.thread_out, rsp_ff.handle};
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.thread_valid};
   assign rsp_tlast  = rsp_ff.last;

   `WLQ_ASSERT_IMPL(a_empty_list_null, clock, reset, count_ff == '0, head_ff == NIL_PTR && tail_ff == NIL_PTR)
   `WLQ_ASSERT_IMPL(a_count_matches_used, clock, reset, 1'b1, $countones(used_ff) == count_ff)
   `WLQ_ASSERT_IMPL(a_unlink_slot_used, clock, reset, state_ff == ST_UNLINK, used_ff[cur_ff])
   `WLQ_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_tvalid && req_tready, state_ff == ST_EXEC)

endmodule

// File: sim/tb.sv
module tb;

   localparam int NSLOT      = wlq_pkg::SLOTS_DEFAULT;
   localparam logic [4:0] NIL = 5'd16;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_ITEMS  = 76;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [15:0] thread_id, [19:16] waiter_handle, rest zero
   logic [wlq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // [1:0] op
   logic [wlq_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [3:0] handle, [19:4] thread_out, [24:20] waiter_total, rest zero
   logic [wlq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // [0] thread_valid, [2:1] status
   logic [wlq_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   waiter_list_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the waiter list
   logic        occ       [NSLOT];
   logic [15:0] owner_tid [NSLOT];
   logic [4:0]  link_next [NSLOT];
   logic [4:0]  link_prev [NSLOT];
   logic [4:0]  head_ptr, tail_ptr, waiters;

   wlq_pkg::rsp_type due_responses [$];

   int cycles = 0;
   int n_bad = 0;
   int n_sent = 0;
   int n_checked = 0;
   int full_hits = 0;
   int longest_drain = 0;
   int hold_asked = 0;
   int hold_given = 0;
   int hold_left = 0;
   bit steady = 1'b0;

   typedef struct {
      wlq_pkg::op_type  op;
      logic [15:0]      tid;
      logic [3:0]       hdl;
      int               reps;
      bit               typed;
      wlq_pkg::rsp_type want;
   } step_row;

   step_row plan [15];

   function automatic void post(logic [3:0] hdl, logic [15:0] tid, logic vld,
                                wlq_pkg::status_type st, logic fin);
      wlq_pkg::rsp_type r;
      r.handle       = hdl;
      r.thread_out   = tid;
      r.thread_valid = vld;
      r.status       = st;
      r.waiter_total = waiters;
      r.last         = fin;
      due_responses.push_back(r);
   endfunction

   function automatic void unlink(logic [4:0] s);
      logic [4:0] p, n;
      p = link_prev[s];
      n = link_next[s];
      if (p != NIL) link_next[p] = n;
      else head_ptr = n;
      if (n != NIL) link_prev[n] = p;
      else tail_ptr = p;
      link_prev[s] = NIL;
      link_next[s] = NIL;
      occ[s]       = 1'b0;
      waiters      = waiters - 5'd1;
   endfunction

   // apply one request to the shadow list and queue the responses it causes
   function automatic void queue_apply(wlq_pkg::op_type op, logic [15:0] tid,
                                       logic [3:0] hdl);
      logic [4:0]  s;
      logic [15:0] popped [$];
      s = NIL;
      case (op)
         wlq_pkg::OP_ADD: begin
            for (int i = NSLOT - 1; i >= 0; i--)
               if (!occ[i]) s = 5'(i);
            if (s == NIL) begin
               full_hits++;
               post(4'd0, 16'd0, 1'b0, wlq_pkg::STATUS_FULL, 1'b1);
            end else begin
               occ[s]       = 1'b1;
               owner_tid[s] = tid;
               link_next[s] = NIL;
               link_prev[s] = tail_ptr;
               if (tail_ptr != NIL) link_next[tail_ptr] = s;
               else head_ptr = s;
               tail_ptr = s;
               waiters  = waiters + 5'd1;
               post(s[3:0], 16'd0, 1'b0, wlq_pkg::STATUS_OK, 1'b1);
            end
         end
         wlq_pkg::OP_REMOVE: begin
            if (!occ[hdl]) begin
               post(4'd0, 16'd0, 1'b0, wlq_pkg::STATUS_MISS, 1'b1);
            end else begin
               unlink({1'b0, hdl});
               post(4'd0, 16'd0, 1'b0, wlq_pkg::STATUS_OK, 1'b1);
            end
         end
         wlq_pkg::OP_SHIFT: begin
            if (head_ptr == NIL) begin
               post(4'd0, 16'd0, 1'b0, wlq_pkg::STATUS_MISS, 1'b1);
            end else begin
               s = head_ptr;
               unlink(s);
               post(4'd0, owner_tid[s], 1'b1, wlq_pkg::STATUS_OK, 1'b1);
            end
         end
         default: begin
            if (head_ptr == NIL) begin
               post(4'd0, 16'd0, 1'b0, wlq_pkg::STATUS_MISS, 1'b1);
            end else begin
               while (head_ptr != NIL && popped.size() < wlq_pkg::RESULT_LIMIT) begin
                  s = head_ptr;
                  popped.push_back(owner_tid[s]);
                  unlink(s);
               end
               // every drain response carries the count left after the whole drain
               foreach (popped[i])
                  post(4'd0, popped[i], 1'b1, wlq_pkg::STATUS_OK, i == popped.size() - 1);
               if (popped.size() > longest_drain) longest_drain = popped.size();
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         n_bad++;
         if (n_bad <= 10)
            $display("mismatch at cycle %0d: %s expected %0h, got %0h",
                     cycles, name, want, got);
      end
   endfunction

   task automatic offer(wlq_pkg::op_type op, logic [15:0] tid, logic [3:0] hdl);
      if (!steady && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, hdl, tid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
      queue_apply(op, tid, hdl);
   endtask

   task automatic drain_wait;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_responses.size() != 0) @(posedge clock);
   endtask

   task automatic random_item;
      int               r;
      logic [3:0]       hdl;
      logic [3:0]       busy [$];
      wlq_pkg::op_type  op;
      r   = $urandom_range(0, 99);
      hdl = 4'($urandom_range(0, 15));
      if (r < 45) op = wlq_pkg::OP_ADD;
      else if (r < 70) op = wlq_pkg::OP_REMOVE;
      else if (r < 88) op = wlq_pkg::OP_SHIFT;
      else op = wlq_pkg::OP_DRAIN;
      if (op == wlq_pkg::OP_REMOVE && $urandom_range(0, 99) < 80) begin
         for (int i = 0; i < NSLOT; i++)
            if (occ[i]) busy.push_back(4'(i));
         if (busy.size() != 0) hdl = busy[$urandom_range(0, busy.size() - 1)];
      end
      offer(op, 16'($urandom_range(0, 65535)), hdl);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, due_responses.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response side: random backpressure, always ready while steady, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_given) begin
         hold_given <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 35);
      end
   end

   always @(posedge clock) begin
      wlq_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_responses.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
               $display("unexpected transaction at cycle %0d: tdata %0h tuser %0h",
                        cycles, rsp_tdata, rsp_tuser);
         end else begin
            want = due_responses.pop_front();
            n_checked++;
            check_field("handle",       want.handle,       rsp_tdata[3:0]);
            check_field("thread_out",   want.thread_out,   rsp_tdata[19:4]);
            check_field("waiter_total", want.waiter_total, rsp_tdata[24:20]);
            check_field("tdata pad",    0,                 rsp_tdata[31:25]);
            check_field("thread_valid", want.thread_valid, rsp_tuser[0]);
            check_field("status",       want.status,       rsp_tuser[2:1]);
            check_field("last",         want.last,         rsp_tlast);
         end
      end
   end

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         occ[i]       = 1'b0;
         owner_tid[i] = '0;
         link_next[i] = NIL;
         link_prev[i] = NIL;
      end
      head_ptr = NIL;
      tail_ptr = NIL;
      waiters  = '0;

      plan = '{
         '{wlq_pkg::OP_SHIFT,  16'h0000, 4'd0,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_MISS, 5'd0,  1'b1}},
         '{wlq_pkg::OP_DRAIN,  16'h0000, 4'd0,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_MISS, 5'd0,  1'b1}},
         '{wlq_pkg::OP_REMOVE, 16'h0000, 4'd0,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_MISS, 5'd0,  1'b1}},
         '{wlq_pkg::OP_REMOVE, 16'h0000, 4'd15, 1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_MISS, 5'd0,  1'b1}},
         '{wlq_pkg::OP_ADD,    16'h0000, 4'd0,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_OK,   5'd1,  1'b1}},
         '{wlq_pkg::OP_ADD,    16'hFFFF, 4'd0,  1,  1'b1,
           '{4'd1, 16'h0000, 1'b0, wlq_pkg::STATUS_OK,   5'd2,  1'b1}},
         '{wlq_pkg::OP_ADD,    16'hA5A0, 4'd0,  14, 1'b0, '0},
         '{wlq_pkg::OP_ADD,    16'h1234, 4'd0,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_FULL, 5'd16, 1'b1}},
         '{wlq_pkg::OP_REMOVE, 16'h0000, 4'd15, 1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_OK,   5'd15, 1'b1}},
         '{wlq_pkg::OP_REMOVE, 16'h0000, 4'd0,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_OK,   5'd14, 1'b1}},
         '{wlq_pkg::OP_REMOVE, 16'h0000, 4'd7,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_OK,   5'd13, 1'b1}},
         '{wlq_pkg::OP_ADD,    16'h5A5A, 4'd0,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_OK,   5'd14, 1'b1}},
         '{wlq_pkg::OP_SHIFT,  16'h0000, 4'd0,  1,  1'b1,
           '{4'd0, 16'hFFFF, 1'b1, wlq_pkg::STATUS_OK,   5'd13, 1'b1}},
         '{wlq_pkg::OP_DRAIN,  16'h0000, 4'd0,  1,  1'b0, '0},
         '{wlq_pkg::OP_REMOVE, 16'h0000, 4'd3,  1,  1'b1,
           '{4'd0, 16'h0000, 1'b0, wlq_pkg::STATUS_MISS, 5'd0,  1'b1}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (int r = 0; r < plan[i].reps; r++) begin
            offer(plan[i].op, plan[i].tid + 16'(r), plan[i].hdl);
            // hand-derived rows override the predictor's single response
            if (plan[i].typed) begin
               void'(due_responses.pop_back());
               due_responses.push_back(plan[i].want);
            end
         end
      end

      // fill the table and drain it while responses are held back
      drain_wait();
      hold_asked <= hold_asked + 1;
      repeat (17) offer(wlq_pkg::OP_ADD, 16'($urandom_range(0, 65535)),
                        4'($urandom_range(0, 15)));
      offer(wlq_pkg::OP_DRAIN, 16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == 30) drain_wait();
         if (i == 40) steady <= 1'b1;
         if (i == 65) steady <= 1'b0;
         random_item();
      end
      drain_wait();
      repeat (30) @(posedge clock);

      $display("%0d requests sent, %0d responses checked", n_sent, n_checked);
      $display("table full %0d times, longest drain %0d waiters", full_hits, longest_drain);
      if (n_bad == 0 && due_responses.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
